FILE: sv/htna_pkg.sv
package htna_pkg;

   // Edge defaults and the hardware ceiling on any edge
   localparam int unsigned DEFAULT_MAX_EDGE = 64;
   localparam int unsigned HW_EDGE_CAP      = 64;

   // 360 degrees in 1/64 degree units, rounding bias, reciprocal of 15 in Q16
   localparam int unsigned DIR_FULL   = 23040;
   localparam int unsigned ROUND_HALF = 3840;
   localparam int unsigned RECIP_15   = 4369;

   // Register stages from request to response
   localparam int unsigned PIPE_DEPTH = 8;

   typedef enum logic [0:0] {
      CSR_COLUMNS = 1'b0,
      CSR_ROWS    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      SIDE_0 = 3'd0,
      SIDE_1 = 3'd1,
      SIDE_2 = 3'd2,
      SIDE_3 = 3'd3,
      SIDE_4 = 3'd4,
      SIDE_5 = 3'd5
   } side_type;

   typedef struct packed {
      logic [6:0] cols;
      logic [6:0] rows;
      logic [6:0] longer;
   } edges_type;

   typedef struct packed {
      logic [5:0]  hc;
      logic [5:0]  hr;
      logic [14:0] dir;
      logic [5:0]  ring;
   } front_type;

   typedef struct packed {
      logic [5:0] hc;
      logic [5:0] hr;
      logic [5:0] ring;
      logic [8:0] pos;
   } posn_type;

   // Clamp an edge register: zero becomes one, large values saturate at cap
   function automatic logic [6:0] edge_limit(input logic [6:0] v, input logic [6:0] cap);
      logic [6:0] r;
      r = v;
      if (v == 7'd0) r = 7'd1;
      else if (v > cap) r = cap;
      return r;
   endfunction

   // One restoring step of a remainder: subtract div shifted by sh if it fits
   function automatic logic [7:0] mod_step(input logic [7:0] rem, input logic [6:0] div,
                                           input int unsigned sh);
      logic [14:0] shifted;
      logic [14:0] wide;
      shifted = 15'(div) << sh;
      wide    = {7'd0, rem};
      if (wide >= shifted) wide = wide - shifted;
      return wide[7:0];
   endfunction

endpackage

FILE: sv/hex_torus_neighbour_address.sv
// Hexagonal ring neighbour address on a torus grid.
//
// Request: pulse start with req_home_col, req_home_row, req_direction_deg64
// and req_ring_distance. busy is always low, so a request is taken on every
// cycle that start is high: one request per clock, back to back.
// Response: rsp_valid is high for one cycle with rsp_cell_col/rsp_cell_row.
// Results come out in request order. The
// receiver cannot stall; the response must be taken in its cycle.
// The design is an 8-stage pipeline: ring and home reductions by
// restoring remainder steps (two stages), the position product, the
// reciprocal divide by 15 and its correction, side split, and two stages of
// offset reduction and torus wrap.
// Configuration: csr_we with csr_index (columns, rows) and csr_wdata writes
// an edge register; write only while no request is in flight.
// Reset: synchronous; clears the pipeline valid bits and sets both edges to
// the largest supported edge.
module hex_torus_neighbour_address
   import htna_pkg::*;
#(
   parameter int unsigned MAX_EDGE = DEFAULT_MAX_EDGE
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [5:0]    req_home_col,
   input  logic [5:0]    req_home_row,
   input  logic [15:0]   req_direction_deg64,
   input  logic [7:0]    req_ring_distance,
   output logic          rsp_valid,
   output logic [5:0]    rsp_cell_col,
   output logic [5:0]    rsp_cell_row,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [6:0]    csr_wdata
);

   localparam int unsigned EDGE_CAP = (MAX_EDGE < HW_EDGE_CAP) ? MAX_EDGE : HW_EDGE_CAP;
   localparam logic [6:0]  CAP_V    = 7'(EDGE_CAP);

   logic [6:0] cols_ff, cols_in;
   logic [6:0] rows_ff, rows_in;
   edges_type  edges;
   logic       accept;
   logic       front_valid, pos_valid;
   front_type  front_data;
   posn_type   pos_data;

   // Store edges already clamped, so every stage sees legal values
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COLUMNS: cols_in = edge_limit(csr_wdata, CAP_V);
            CSR_ROWS:    rows_in = edge_limit(csr_wdata, CAP_V);
            default:     cols_in = cols_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= CAP_V;
         rows_ff <= CAP_V;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   assign edges.cols   = cols_ff;
   assign edges.rows   = rows_ff;
   assign edges.longer = (cols_ff > rows_ff) ? cols_ff : rows_ff;

   // Pipeline never stalls: always ready for a request
   assign busy   = 1'b0;
   assign accept = start && !busy;

   htna_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .home_col        (req_home_col),
      .home_row        (req_home_row),
      .direction_deg64 (req_direction_deg64),
      .ring_distance   (req_ring_distance),
      .edges           (edges),
      .out_valid       (front_valid),
      .out_data        (front_data)
   );

   htna_pos u_pos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (pos_valid),
      .out_data  (pos_data)
   );

   htna_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pos_valid),
      .in_data   (pos_data),
      .edges     (edges),
      .out_valid (rsp_valid),
      .cell_col  (rsp_cell_col),
      .cell_row  (rsp_cell_row)
   );

endmodule

FILE: sv/htna_front.sv
module htna_front
   import htna_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [5:0]  home_col,
   input  logic [5:0]  home_row,
   input  logic [15:0] direction_deg64,
   input  logic [7:0]  ring_distance,
   input  edges_type   edges,
   output logic        out_valid,
   output front_type   out_data
);

   logic        valid1_ff;
   logic [5:0]  hc1_ff, hc1_in;
   logic [5:0]  hr1_ff, hr1_in;
   logic [14:0] dir1_ff, dir1_in;
   logic [7:0]  ring1_ff, ring1_in;
   logic        valid2_ff;
   front_type   out_ff, out_in;

   // Stage 1: fold direction into one turn, wrap home cell, upper ring steps
   always_comb begin
      logic [7:0] rc;
      logic [7:0] rr;
      logic [7:0] rd;
      if (direction_deg64 >= 16'(2 * DIR_FULL)) begin
         dir1_in = 15'(direction_deg64 - 16'(2 * DIR_FULL));
      end else if (direction_deg64 >= 16'(DIR_FULL)) begin
         dir1_in = 15'(direction_deg64 - 16'(DIR_FULL));
      end else begin
         dir1_in = direction_deg64[14:0];
      end
      rc = {2'b00, home_col};
      rr = {2'b00, home_row};
      for (int k = 5; k >= 0; k--) begin
         rc = mod_step(rc, edges.cols, k);
         rr = mod_step(rr, edges.rows, k);
      end
      hc1_in = rc[5:0];
      hr1_in = rr[5:0];
      rd = ring_distance;
      for (int k = 7; k >= 4; k--) begin
         rd = mod_step(rd, edges.longer, k);
      end
      ring1_in = rd;
   end

   // Stage 2: finish the ring distance remainder
   always_comb begin
      logic [7:0] rd;
      rd = ring1_ff;
      for (int k = 3; k >= 0; k--) begin
         rd = mod_step(rd, edges.longer, k);
      end
      out_in.hc   = hc1_ff;
      out_in.hr   = hr1_ff;
      out_in.dir  = dir1_ff;
      out_in.ring = rd[5:0];
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      hc1_ff   <= hc1_in;
      hr1_ff   <= hr1_in;
      dir1_ff  <= dir1_in;
      ring1_ff <= ring1_in;
      out_ff   <= out_in;
   end

   assign out_valid = valid2_ff;
   assign out_data  = out_ff;

endmodule

FILE: sv/htna_pos.sv
module htna_pos
   import htna_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output posn_type  out_data
);

   logic        valid3_ff, valid4_ff, valid5_ff;
   logic [12:0] y3_ff, y3_in;
   logic [5:0]  hc3_ff, hr3_ff, dist3_ff;
   logic [12:0] y4_ff;
   logic [8:0]  q4_ff, q4_in;
   logic [5:0]  hc4_ff, hr4_ff, dist4_ff;
   posn_type    out_ff, out_in;

   // Stage 3: scaled position 2*D*d + bias, then drop the factor 512
   always_comb begin
      logic [20:0] prod;
      logic [21:0] x;
      prod  = 21'(in_data.dir) * 21'(in_data.ring);
      x     = {prod, 1'b0} + 22'(ROUND_HALF);
      y3_in = x[21:9];
   end

   // Stage 4: estimate the quotient by 15 with a Q16 reciprocal
   always_comb begin
      logic [25:0] m;
      m     = 26'(y3_ff) * 26'(RECIP_15);
      q4_in = m[24:16];
   end

   // Stage 5: correct the estimate, fold a full perimeter back to zero
   always_comb begin
      logic [12:0] r;
      logic [8:0]  p;
      logic [8:0]  six_d;
      r     = y4_ff - (13'({q4_ff, 4'b0000}) - 13'(q4_ff));
      p     = (r >= 13'd15) ? q4_ff + 9'd1 : q4_ff;
      six_d = 9'(dist4_ff) * 9'd6;
      if (p >= six_d) p = 9'd0;
      out_in.hc   = hc4_ff;
      out_in.hr   = hr4_ff;
      out_in.ring = dist4_ff;
      out_in.pos  = p;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         valid3_ff <= in_valid;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      y3_ff    <= y3_in;
      hc3_ff   <= in_data.hc;
      hr3_ff   <= in_data.hr;
      dist3_ff <= in_data.ring;
      y4_ff    <= y3_ff;
      q4_ff    <= q4_in;
      hc4_ff   <= hc3_ff;
      hr4_ff   <= hr3_ff;
      dist4_ff <= dist3_ff;
      out_ff   <= out_in;
   end

   assign out_valid = valid5_ff;
   assign out_data  = out_ff;

endmodule

FILE: sv/htna_wrap.sv
module htna_wrap
   import htna_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  posn_type   in_data,
   input  edges_type  edges,
   output logic       out_valid,
   output logic [5:0] cell_col,
   output logic [5:0] cell_row
);

   logic              valid6_ff, valid7_ff, valid8_ff;
   logic signed [6:0] dc6_ff, dc6_in, dr6_ff, dr6_in;
   logic [5:0]        hc6_ff, hr6_ff;
   logic [5:0]        uc7_ff, uc7_in, ur7_ff, ur7_in;
   logic              nc7_ff, nr7_ff;
   logic [5:0]        hc7_ff, hr7_ff;
   logic [5:0]        col8_ff, col8_in, row8_ff, row8_in;

   // Stage 6: split the position into side and offset, form the cell offset
   always_comb begin
      logic [8:0]        mult [1:5];
      logic [2:0]        cnt;
      logic [8:0]        base;
      logic signed [6:0] d;
      logic signed [6:0] o;
      side_type          side;
      cnt = 3'd0;
      for (int k = 1; k <= 5; k++) begin
         mult[k] = 9'(in_data.ring) * 9'(k);
         if (in_data.pos >= mult[k]) cnt = cnt + 3'd1;
      end
      side = side_type'(cnt);
      case (side)
         SIDE_1:  base = mult[1];
         SIDE_2:  base = mult[2];
         SIDE_3:  base = mult[3];
         SIDE_4:  base = mult[4];
         SIDE_5:  base = mult[5];
         default: base = 9'd0;
      endcase
      d = $signed({1'b0, in_data.ring});
      o = $signed(7'(in_data.pos - base));
      case (side)
         SIDE_0:  begin dc6_in = o;      dr6_in = -d;     end
         SIDE_1:  begin dc6_in = d;      dr6_in = o - d;  end
         SIDE_2:  begin dc6_in = d - o;  dr6_in = o;      end
         SIDE_3:  begin dc6_in = -o;     dr6_in = d;      end
         SIDE_4:  begin dc6_in = -d;     dr6_in = d - o;  end
         default: begin dc6_in = o - d;  dr6_in = -o;     end
      endcase
      if (in_data.ring == 6'd0) begin
         dc6_in = 7'sd0;
         dr6_in = 7'sd0;
      end
   end

   // Stage 7: reduce the offset magnitudes modulo the edges
   always_comb begin
      logic [6:0] mc;
      logic [6:0] mr;
      logic [7:0] rc;
      logic [7:0] rr;
      mc = dc6_ff[6] ? 7'(-dc6_ff) : 7'(dc6_ff);
      mr = dr6_ff[6] ? 7'(-dr6_ff) : 7'(dr6_ff);
      rc = {1'b0, mc};
      rr = {1'b0, mr};
      for (int k = 5; k >= 0; k--) begin
         rc = mod_step(rc, edges.cols, k);
         rr = mod_step(rr, edges.rows, k);
      end
      uc7_in = rc[5:0];
      ur7_in = rr[5:0];
   end

   // Stage 8: apply the sign, add to home, one wrap into the grid
   always_comb begin
      logic [6:0] ac;
      logic [6:0] ar;
      logic [7:0] sc;
      logic [7:0] sr;
      ac = (nc7_ff && uc7_ff != 6'd0) ? edges.cols - 7'(uc7_ff) : 7'(uc7_ff);
      ar = (nr7_ff && ur7_ff != 6'd0) ? edges.rows - 7'(ur7_ff) : 7'(ur7_ff);
      sc = 8'(hc7_ff) + 8'(ac);
      sr = 8'(hr7_ff) + 8'(ar);
      if (sc >= 8'(edges.cols)) sc = sc - 8'(edges.cols);
      if (sr >= 8'(edges.rows)) sr = sr - 8'(edges.rows);
      col8_in = sc[5:0];
      row8_in = sr[5:0];
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid6_ff <= 1'b0;
         valid7_ff <= 1'b0;
         valid8_ff <= 1'b0;
      end else begin
         valid6_ff <= in_valid;
         valid7_ff <= valid6_ff;
         valid8_ff <= valid7_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      dc6_ff  <= dc6_in;
      dr6_ff  <= dr6_in;
      hc6_ff  <= in_data.hc;
      hr6_ff  <= in_data.hr;
      uc7_ff  <= uc7_in;
      ur7_ff  <= ur7_in;
      nc7_ff  <= dc6_ff[6];
      nr7_ff  <= dr6_ff[6];
      hc7_ff  <= hc6_ff;
      hr7_ff  <= hr6_ff;
      col8_ff <= col8_in;
      row8_ff <= row8_in;
   end

   assign out_valid = valid8_ff;
   assign cell_col  = col8_ff;
   assign cell_row  = row8_ff;

endmodule

FILE: sv/htna_checker.sv
module htna_checker
   import htna_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // Block takes a request every cycle
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised on a non-stalling pipeline");

   // Every request yields a response after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_valid)
      else $error("request without response at fixed latency");

   // No response without a matching request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("response without a request");

endmodule

bind hex_torus_neighbour_address htna_checker u_htna_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
